[src/bcdec_pkg.sv]
// Shared types and constants for the BC1/BC2/BC3 block decoder.
// Used by bcdec_palette and bc1_bc2_bc3_block_decoder; depends on nothing.
package bcdec_pkg;

	// format_mode codes
	localparam logic [1:0] MODE_DXT1 = 2'd0;
	localparam logic [1:0] MODE_DXT3 = 2'd1;
	localparam logic [1:0] MODE_DXT5 = 2'd2;
	localparam logic [1:0] MODE_RSVD = 2'd3; // decodes as DXT5

	// reciprocals for constant division
	localparam logic [9:0]  RECIP3 = 10'd683;   // x*683  >> 11 == x/3 for x < 2048
	localparam logic [12:0] RECIP5 = 13'd6554;  // x*6554 >> 15 == x/5 for x < 16384
	localparam logic [12:0] RECIP7 = 13'd4682;  // x*4682 >> 15 == x/7 for x < 5461

	localparam logic [1:0] CIDX_TRANSP = 2'd3;
	localparam logic [3:0] LAST_PIX    = 4'd15;

	// one color: [0] blue, [1] green, [2] red
	typedef logic [2:0][7:0] rgb_t;

	// decoded block: palettes plus the per-pixel indices
	typedef struct packed {
		rgb_t [3:0]       cpal;
		logic [7:0][7:0]  apal;
		logic [31:0]      cidx;
		logic [63:0]      ablk;
		logic             dxt5;
		logic             dxt3;
		logic             three_col;
	} blk_t;

endpackage

[src/bcdec_palette.sv]
// Three-stage block pipeline: capture the block, unpack endpoints and form weighted sums,
// divide into color and alpha palettes. Depends on bcdec_pkg.
module bcdec_palette (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          format_mode,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [63:0]         color_block,
	input  logic [63:0]         alpha_block,
	output logic                out_valid,
	input  logic                out_ready,
	output bcdec_pkg::blk_t     out_blk
);
	import bcdec_pkg::*;

	logic rdy1, rdy2, rdy3;
	logic v1_s1, v2_s2, v3_s3;

	// stage 1 registers
	logic [63:0] cblk_s1, ablk_s1;
	logic        dxt5_s1, dxt3_s1, three_s1, alpha7_s1;

	// stage 2 registers
	rgb_t              e0x_s2, e1x_s2, mid_s2;
	logic [2:0][9:0]   sum2_s2, sum3_s2;
	logic [5:0][10:0]  num_s2;
	logic [31:0]       cidx_s2;
	logic [63:0]       ablk_s2;
	logic              dxt5_s2, dxt3_s2, three_s2, alpha7_s2;

	// stage 3 register
	blk_t blk_s3;

	logic        in_dxt5, in_dxt3;
	rgb_t        e0x_c, e1x_c, mid_c;
	logic [2:0][9:0]  sum2_c, sum3_c;
	logic [5:0][10:0] num_c;
	blk_t        blk_c;

	// per-stage ready: a stage moves when empty or when its successor takes it
	assign rdy3     = !v3_s3 || out_ready;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign in_ready = rdy1;
	assign out_valid = v3_s3;
	assign out_blk   = blk_s3;

	// decode mode; code 3 behaves as DXT5
	assign in_dxt5 = (format_mode == MODE_DXT5) || (format_mode == MODE_RSVD);
	assign in_dxt3 = (format_mode == MODE_DXT3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= in_valid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
		end
	end

	// stage 1: capture block and mode flags
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			cblk_s1   <= color_block;
			ablk_s1   <= alpha_block;
			dxt5_s1   <= in_dxt5;
			dxt3_s1   <= in_dxt3;
			three_s1  <= (format_mode == MODE_DXT1) && (color_block[15:0] <= color_block[31:16]);
			alpha7_s1 <= alpha_block[7:0] > alpha_block[15:8];
		end
	end

	// expand endpoints and form per-channel sums
	always_comb begin
		logic [8:0] pair;
		e0x_c[0] = {cblk_s1[4:0], 3'b000};
		e0x_c[1] = {cblk_s1[10:5], 2'b00};
		e0x_c[2] = {cblk_s1[15:11], 3'b000};
		e1x_c[0] = {cblk_s1[20:16], 3'b000};
		e1x_c[1] = {cblk_s1[26:21], 2'b00};
		e1x_c[2] = {cblk_s1[31:27], 3'b000};
		for (int ch = 0; ch < 3; ch++) begin
			sum2_c[ch] = {1'b0, e0x_c[ch], 1'b0} + {2'b00, e1x_c[ch]};
			sum3_c[ch] = {2'b00, e0x_c[ch]} + {1'b0, e1x_c[ch], 1'b0};
			pair       = {1'b0, e0x_c[ch]} + {1'b0, e1x_c[ch]};
			mid_c[ch]  = pair[8:1];
		end
	end

	// alpha palette numerators, seven-step or five-step weights
	always_comb begin
		for (int z = 0; z < 6; z++) begin
			if (alpha7_s1) begin
				num_c[z] = 11'(6 - z) * {3'b000, ablk_s1[7:0]}
					+ 11'(z + 1) * {3'b000, ablk_s1[15:8]};
			end else if (z < 4) begin
				num_c[z] = 11'(4 - z) * {3'b000, ablk_s1[7:0]}
					+ 11'(z + 1) * {3'b000, ablk_s1[15:8]};
			end else begin
				num_c[z] = '0;
			end
		end
	end

	// stage 2 register
	always_ff @(posedge clk) begin
		if (rdy2 && v1_s1) begin
			e0x_s2    <= e0x_c;
			e1x_s2    <= e1x_c;
			mid_s2    <= mid_c;
			sum2_s2   <= sum2_c;
			sum3_s2   <= sum3_c;
			num_s2    <= num_c;
			cidx_s2   <= cblk_s1[63:32];
			ablk_s2   <= ablk_s1;
			dxt5_s2   <= dxt5_s1;
			dxt3_s2   <= dxt3_s1;
			three_s2  <= three_s1;
			alpha7_s2 <= alpha7_s1;
		end
	end

	// divide by 3, 5 or 7 with reciprocal multiplies and pick palette entries
	always_comb begin
		logic [19:0] p2, p3;
		logic [23:0] pa;
		logic [12:0] k;
		blk_c.cidx      = cidx_s2;
		blk_c.ablk      = ablk_s2;
		blk_c.dxt5      = dxt5_s2;
		blk_c.dxt3      = dxt3_s2;
		blk_c.three_col = three_s2;
		blk_c.cpal[0]   = e0x_s2;
		blk_c.cpal[1]   = e1x_s2;
		for (int ch = 0; ch < 3; ch++) begin
			p2 = sum2_s2[ch] * RECIP3;
			p3 = sum3_s2[ch] * RECIP3;
			blk_c.cpal[2][ch] = three_s2 ? mid_s2[ch] : p2[18:11];
			blk_c.cpal[3][ch] = three_s2 ? 8'd0 : p3[18:11];
		end
		blk_c.apal[0] = ablk_s2[7:0];
		blk_c.apal[1] = ablk_s2[15:8];
		k = alpha7_s2 ? RECIP7 : RECIP5;
		for (int z = 0; z < 6; z++) begin
			pa = num_s2[z] * k;
			if (alpha7_s2 || z < 4) begin
				blk_c.apal[z + 2] = pa[22:15];
			end else if (z == 4) begin
				blk_c.apal[z + 2] = 8'd0;
			end else begin
				blk_c.apal[z + 2] = 8'd255;
			end
		end
	end

	// stage 3 register
	always_ff @(posedge clk) begin
		if (rdy3 && v2_s2) begin
			blk_s3 <= blk_c;
		end
	end

endmodule

[src/bc1_bc2_bc3_block_decoder.sv]
// Top level of the BC1/BC2/BC3 (DXT1/DXT3/DXT5) block decoder.
// Depends on bcdec_pkg and bcdec_palette.

// Takes one 128-bit compressed 4x4 block per input beat and returns its 16
// pixels in raster order, one output beat per cycle while m_axis_tready is
// high, tlast on the sixteenth. A block occupies the pixel serializer until all
// 16 of its pixels are emitted; the next block is taken in while the current
// one is still being emitted. From input beat to first pixel a block passes
// through three palette stages, the serializer and the output register.
// format_mode is written through the cfg channel, which is always ready, and
// is sampled as each block enters; write it only while the decoder is idle.
module bc1_bc2_bc3_block_decoder (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_data,        // format_mode
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,    // color_block[63:0], alpha_block[127:64]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [39:0]  m_axis_tdata,    // blue, green, red, alpha, pixel_col,
	                                      // pixel_row, 4 zero bits
	output logic         m_axis_tlast     // last_pixel
);
	import bcdec_pkg::*;

	logic [1:0]  format_mode_q;
	logic        pal_valid, pal_ready;
	blk_t        pal_blk;

	logic        ser_v_q;
	blk_t        ser_blk_q;
	logic [3:0]  cnt_q;

	logic        out_rdy, emit;
	logic [1:0]  ci;
	logic [5:0]  apos;
	logic [2:0]  ai;
	logic [3:0]  nib;
	rgb_t        pix_rgb;
	logic [7:0]  pix_a;

	logic        out_v_q;
	logic [39:0] out_data_q;
	logic        out_last_q;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q <= MODE_DXT1;
		end else if (cfg_valid) begin
			format_mode_q <= cfg_data;
		end
	end

	bcdec_palette u_palette (
		.clk         (clk),
		.arst_n      (arst_n),
		.format_mode (format_mode_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.color_block (s_axis_tdata[63:0]),
		.alpha_block (s_axis_tdata[127:64]),
		.out_valid   (pal_valid),
		.out_ready   (pal_ready),
		.out_blk     (pal_blk)
	);

	// serializer: hold one decoded block, emit a pixel per free output slot
	assign out_rdy   = !out_v_q || m_axis_tready;
	assign emit      = ser_v_q && out_rdy;
	assign pal_ready = !ser_v_q || (emit && (cnt_q == LAST_PIX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_v_q <= 1'b0;
			cnt_q   <= '0;
		end else if (pal_ready) begin
			ser_v_q <= pal_valid;
			cnt_q   <= '0;
		end else if (emit) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pal_ready && pal_valid) begin
			ser_blk_q <= pal_blk;
		end
	end

	// select the current pixel's color and alpha
	always_comb begin
		ci      = ser_blk_q.cidx[{cnt_q, 1'b0} +: 2];
		apos    = 6'd16 + {2'b00, cnt_q} + {1'b0, cnt_q, 1'b0};
		ai      = ser_blk_q.ablk[apos +: 3];
		nib     = ser_blk_q.ablk[{cnt_q, 2'b00} +: 4];
		pix_rgb = ser_blk_q.cpal[ci];
		if (ser_blk_q.dxt5) begin
			pix_a = ser_blk_q.apal[ai];
		end else if (ser_blk_q.dxt3) begin
			pix_a = {nib, 4'b0000};
		end else if (ser_blk_q.three_col && (ci == CIDX_TRANSP)) begin
			pix_a = 8'd0;
		end else begin
			pix_a = 8'd255;
		end
	end

	// output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_rdy) begin
			out_v_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= {4'b0000, cnt_q[3:2], cnt_q[1:0], pix_a,
				pix_rgb[2], pix_rgb[1], pix_rgb[0]};
			out_last_q <= (cnt_q == LAST_PIX);
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule
